[sv/rtt_pkg.sv]
// shared types, codes and defaults for the request timeout table
package rtt_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_ID_BITS     = 16;
    localparam int DEF_TIME_BITS   = 32;

    localparam int MODE_BITS   = 2;
    localparam int ID_PORT_W   = 16;
    localparam int TIME_PORT_W = 32;
    localparam int STATUS_BITS = 3;

    localparam logic [MODE_BITS-1:0] MODE_SET    = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_TICK   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    localparam logic [STATUS_BITS-1:0] RES_INSERTED  = 3'd0;
    localparam logic [STATUS_BITS-1:0] RES_UPDATED   = 3'd1;
    localparam logic [STATUS_BITS-1:0] RES_FULL      = 3'd2;
    localparam logic [STATUS_BITS-1:0] RES_REMOVED   = 3'd3;
    localparam logic [STATUS_BITS-1:0] RES_NOT_FOUND = 3'd4;
    localparam logic [STATUS_BITS-1:0] RES_EXPIRED   = 3'd5;
    localparam logic [STATUS_BITS-1:0] RES_NONE      = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic walk_done;
    } ctl_sts_t;

endpackage

[sv/rtt_ctrl.sv]
// controller state machine for the request timeout table
module rtt_ctrl
    import rtt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MODE_BITS-1:0] mode,
    input  ctl_sts_t             sts,
    output ctl_cmd_t             cmd,
    output logic                 busy
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && (mode != MODE_UNUSED))
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start && (mode != MODE_UNUSED);
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

[sv/rtt_dp.sv]
// datapath of the request timeout table: entry memory, walk counters, result register
module rtt_dp
    import rtt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_cmd_t               cmd,
    output ctl_sts_t               sts,
    input  logic [MODE_BITS-1:0]   mode,
    input  logic [ID_PORT_W-1:0]   request_id,
    input  logic [TIME_PORT_W-1:0] deadline,
    input  logic [TIME_PORT_W-1:0] now_time,
    output logic                   result_valid,
    output logic [STATUS_BITS-1:0] status,
    output logic [ID_PORT_W-1:0]   expired_id,
    output logic                   last
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    logic [ID_BITS-1:0]   mem_id [TABLE_DEPTH];
    logic [TIME_BITS-1:0] mem_dl [TABLE_DEPTH];

    logic [MODE_BITS-1:0]   mode_reg,  mode_next;
    logic [ID_BITS-1:0]     id_reg,    id_next;
    logic [TIME_BITS-1:0]   dl_reg,    dl_next;
    logic [TIME_BITS-1:0]   now_reg,   now_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       rd_reg,    rd_next;
    logic [CNT_W-1:0]       wr_reg,    wr_next;
    logic                   pend_reg,  pend_next;
    logic                   found_reg, found_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic [ID_BITS-1:0]     hold_id_reg,    hold_id_next;
    logic                   out_valid_reg,  out_valid_next;
    logic [STATUS_BITS-1:0] status_reg,     status_next;
    logic [ID_BITS-1:0]     out_id_reg,     out_id_next;
    logic                   last_reg,       last_next;

    logic [ID_BITS-1:0]   rd_id_reg;
    logic [TIME_BITS-1:0] rd_dl_reg;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ID_BITS-1:0]   mem_wid;
    logic [TIME_BITS-1:0] mem_wdl;
    logic                 mem_re;
    logic                 is_tick;
    logic                 drop;

    assign is_tick = (mode_reg == MODE_TICK);
    assign drop    = is_tick ? (rd_dl_reg <= now_reg) : (rd_id_reg == id_reg);
    assign mem_re  = cmd.step && (rd_reg < count_reg);

    assign sts.walk_done = (rd_reg == count_reg) && !pend_reg;

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_id[mem_waddr] <= mem_wid;
            mem_dl[mem_waddr] <= mem_wdl;
        end
        if (mem_re)
        begin
            rd_id_reg <= mem_id[rd_reg[ADDR_W-1:0]];
            rd_dl_reg <= mem_dl[rd_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= MODE_SET;
        end
        else
        begin
            count_reg      <= count_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            mode_reg       <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        dl_reg      <= dl_next;
        now_reg     <= now_next;
        hold_id_reg <= hold_id_next;
        status_reg  <= status_next;
        out_id_reg  <= out_id_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        mode_next       = mode_reg;
        id_next         = id_reg;
        dl_next         = dl_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        out_valid_next  = 1'b0;
        status_next     = status_reg;
        out_id_next     = out_id_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_reg[ADDR_W-1:0];
        mem_wid         = rd_id_reg;
        mem_wdl         = rd_dl_reg;

        if (cmd.load)
        begin
            mode_next       = mode;
            id_next         = ID_BITS'(request_id);
            dl_next         = TIME_BITS'(deadline);
            now_next        = TIME_BITS'(now_time);
            rd_next         = '0;
            wr_next         = '0;
            pend_next       = 1'b0;
            found_next      = 1'b0;
            hold_valid_next = 1'b0;
        end

        if (cmd.step)
        begin
            pend_next = mem_re;
            if (mem_re)
            begin
                rd_next = rd_reg + 1'b1;
            end
            if (pend_reg)
            begin
                if (!drop)
                begin
                    // keep entry, compact toward slot zero
                    mem_we  = 1'b1;
                    wr_next = wr_reg + 1'b1;
                end
                else if (is_tick)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = RES_EXPIRED;
                        out_id_next    = hold_id_reg;
                        last_next      = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_id_next    = rd_id_reg;
                end
                else
                begin
                    found_next = 1'b1;
                end
            end
        end

        if (cmd.finish)
        begin
            out_valid_next  = 1'b1;
            last_next       = 1'b1;
            out_id_next     = '0;
            hold_valid_next = 1'b0;
            count_next      = wr_reg;
            case (mode_reg)
                MODE_SET:
                begin
                    if (found_reg || (count_reg < FULL_COUNT))
                    begin
                        mem_we      = 1'b1;
                        mem_wid     = id_reg;
                        mem_wdl     = dl_reg;
                        count_next  = wr_reg + 1'b1;
                        status_next = found_reg ? RES_UPDATED : RES_INSERTED;
                    end
                    else
                    begin
                        status_next = RES_FULL;
                    end
                end
                MODE_REMOVE:
                begin
                    status_next = found_reg ? RES_REMOVED : RES_NOT_FOUND;
                end
                MODE_TICK:
                begin
                    if (hold_valid_reg)
                    begin
                        status_next = RES_EXPIRED;
                        out_id_next = hold_id_reg;
                    end
                    else
                    begin
                        status_next = RES_NONE;
                    end
                end
                default:
                begin
                    out_valid_next = 1'b0;
                    count_next     = count_reg;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign expired_id   = ID_PORT_W'(out_id_reg);
    assign last         = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above table depth");

    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (wr_reg <= rd_reg) && (rd_reg <= count_reg))
        else $error("compaction write pointer passed read pointer");

    a_last_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> $past(cmd.finish))
        else $error("final result not caused by finish");

    a_hold_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !hold_valid_reg)
        else $error("held expiry survived finish");

    a_count_still_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> $stable(count_reg))
        else $error("entry count changed during walk");

endmodule

[sv/request_timeout_table.sv]
// Request timeout table: start is taken when busy is low; busy then stays high while
// the item is processed, since every item walks the stored entries one per cycle
// through the registered read port of the entry memory and compacts survivors in
// place. A set that finds the table full and a tick both walk all entries. Results
// come as one-cycle result_valid strobes that cannot be held off; a tick emits one
// expiry per expired entry, oldest first, last marking the final result of the item.
// With mode 3, start is not taken and no result is given.
module request_timeout_table
    import rtt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [MODE_BITS-1:0]   mode,
    input  logic [ID_PORT_W-1:0]   request_id,
    input  logic [TIME_PORT_W-1:0] deadline,
    input  logic [TIME_PORT_W-1:0] now_time,
    output logic                   result_valid,
    output logic [STATUS_BITS-1:0] status,
    output logic [ID_PORT_W-1:0]   expired_id,
    output logic                   last
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    rtt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    rtt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .request_id   (request_id),
        .deadline     (deadline),
        .now_time     (now_time),
        .result_valid (result_valid),
        .status       (status),
        .expired_id   (expired_id),
        .last         (last)
    );

endmodule
